[sv/fiap_pkg.sv]
// ----------------------------------------------------------------------------
// fiap_pkg
// shared types, codes and patch tables of the autoload patcher
// ----------------------------------------------------------------------------
`default_nettype none

package fiap_pkg;

  // widths of the fields and registers
  localparam int unsigned ByteW = 8;
  localparam int unsigned ModeW = 2;
  localparam int unsigned SizeW = 19;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = SizeW;
  localparam int unsigned CntW = 3;

  // number of cells in the delay line
  localparam int unsigned NumCells = 8;

  // largest image the block handles; larger sizes saturate to it
  localparam int unsigned MaxImageBytes = 262144;
  localparam logic [SizeW-1:0] MaxSize = SizeW'(MaxImageBytes);
  localparam logic [SizeW-1:0] SmallLimit = 19'h20000;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgAutoloadMode = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgImageSize = 1'b1;

  // autoload modes
  localparam logic [ModeW-1:0] ModeNone = 2'd0;
  localparam logic [ModeW-1:0] ModeDisable = 2'd1;
  localparam logic [ModeW-1:0] ModeSetOn = 2'd2;
  localparam logic [ModeW-1:0] ModeSetOff = 2'd3;

  // signature bytes
  localparam logic [ByteW-1:0] SigFirst = 8'hA5;
  localparam logic [ByteW-1:0] SigAlt = 8'hA4;
  localparam logic [ByteW-1:0] SigLast = 8'h5A;

  // patch values
  localparam logic [ByteW-1:0] EarlyOnSmall = 8'h94;
  localparam logic [ByteW-1:0] EarlyOnLarge = 8'h85;
  localparam logic [ByteW-1:0] EarlyOffSmall = 8'hA5;
  localparam logic [ByteW-1:0] EarlyOffLarge = 8'hB5;
  localparam logic [ByteW-1:0] LateDisable = 8'h00;
  localparam logic [ByteW-1:0] LateOnSmall = 8'h7F;
  localparam logic [ByteW-1:0] LateOnLarge = 8'hBE;
  localparam logic [ByteW-1:0] LateOff = 8'hAA;

  // one entry of the delay line, also the output item
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
    logic             last;
    logic             patched;
    logic             too_small;
  } cell_t;

  // what the tracker hands to the chain for the current item
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
    logic             patched;
    logic             too_small;
    logic             patch_en;
    logic [ByteW-1:0] patch_byte;
  } trk_t;

  // new value of the byte at signature + 2
  function automatic logic [ByteW-1:0] early_patch(logic [ModeW-1:0] mode, logic small_img);
    logic [ByteW-1:0] v;
    if (mode == ModeSetOff) begin
      v = small_img ? EarlyOffSmall : EarlyOffLarge;
    end else begin
      v = small_img ? EarlyOnSmall : EarlyOnLarge;
    end
    return v;
  endfunction

  // new value of the byte at signature + 8; mode none leaves it
  function automatic logic [ByteW-1:0] late_patch(logic [ModeW-1:0] mode, logic small_img,
                                                  logic [ByteW-1:0] b);
    logic [ByteW-1:0] v;
    case (mode)
      ModeDisable: v = LateDisable;
      ModeSetOn:   v = small_img ? LateOnSmall : LateOnLarge;
      ModeSetOff:  v = LateOff;
      default:     v = b;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[sv/fiap_cell.sv]
// ----------------------------------------------------------------------------
// fiap_cell
// one stage of the byte delay line, with an optional byte override
// ----------------------------------------------------------------------------
`default_nettype none

module fiap_cell (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          adv_i,
  input  wire fiap_pkg::cell_t               prev_i,
  input  wire logic                          ovr_en_i,
  input  wire logic [fiap_pkg::ByteW-1:0]    ovr_byte_i,
  output fiap_pkg::cell_t                    cur_o
);

  logic            valid_q, valid_d;
  fiap_pkg::cell_t pay_q, pay_d;

  always_comb begin
    valid_d = valid_q;
    pay_d   = pay_q;
    if (adv_i) begin
      valid_d = prev_i.valid;
      pay_d   = prev_i;
      if (ovr_en_i) begin
        pay_d.data = ovr_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
  end

  always_comb begin
    cur_o       = pay_q;
    cur_o.valid = valid_q;
  end

endmodule

`default_nettype wire

[sv/fiap_track.sv]
// ----------------------------------------------------------------------------
// fiap_track
// image position, signature search and late patch bookkeeping
// ----------------------------------------------------------------------------
`default_nettype none

module fiap_track (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          fire_i,
  input  wire logic [fiap_pkg::ByteW-1:0]    data_byte_i,
  input  wire logic [fiap_pkg::ModeW-1:0]    mode_i,
  input  wire logic [fiap_pkg::SizeW-1:0]    size_i,
  input  wire logic [fiap_pkg::ByteW-1:0]    win_b0_i,
  input  wire logic [fiap_pkg::ByteW-1:0]    win_b1_i,
  output fiap_pkg::trk_t                     trk_o
);

  localparam int unsigned SizeW = fiap_pkg::SizeW;
  localparam int unsigned CntW = fiap_pkg::CntW;

  logic [SizeW-1:0] pos_q, pos_d;
  logic             found_q, found_d;
  logic             err_q, err_d;
  logic             pend_q, pend_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  logic [SizeW-1:0]              size_eff;
  logic [SizeW:0]                pos_x, size_x;
  logic                          small_img, last, search_ok, hit, too_near;
  logic                          late_fire, found_n, err_n;
  logic [fiap_pkg::ByteW-1:0]    b;

  always_comb begin
    size_eff = (size_i > fiap_pkg::MaxSize) ? fiap_pkg::MaxSize : size_i;
    if (size_eff == '0) begin
      size_eff = SizeW'(1);
    end
    pos_x     = {1'b0, pos_q};
    size_x    = {1'b0, size_eff};
    small_img = size_eff <= fiap_pkg::SmallLimit;
    last      = (pos_x + (SizeW+1)'(1)) >= size_x;

    // byte at signature + 8
    late_fire = pend_q && (cnt_q == '0);
    b = late_fire ? fiap_pkg::late_patch(mode_i, small_img, data_byte_i) : data_byte_i;

    // incoming byte sits at signature + 5
    search_ok = (mode_i != fiap_pkg::ModeNone) && !found_q && (pos_q >= SizeW'(5))
                && ((pos_x + (SizeW+1)'(2)) <= size_x);
    hit = search_ok && (win_b0_i == fiap_pkg::SigFirst)
          && ((win_b1_i == fiap_pkg::SigFirst) || (win_b1_i == fiap_pkg::SigAlt))
          && (b == fiap_pkg::SigLast);
    too_near = (pos_x + (SizeW+1)'(3)) >= size_x;
    found_n  = found_q || hit;
    err_n    = err_q || (hit && too_near);

    trk_o.data       = b;
    trk_o.last       = last;
    trk_o.patched    = found_n && !err_n;
    trk_o.too_small  = err_n;
    trk_o.patch_en   = fire_i && hit && !too_near;
    trk_o.patch_byte = fiap_pkg::early_patch(mode_i, small_img);
  end

  always_comb begin
    pos_d   = pos_q;
    found_d = found_q;
    err_d   = err_q;
    pend_d  = pend_q;
    cnt_d   = cnt_q;
    if (fire_i) begin
      if (last) begin
        pos_d   = '0;
        found_d = 1'b0;
        err_d   = 1'b0;
        pend_d  = 1'b0;
        cnt_d   = '0;
      end else begin
        pos_d   = pos_q + SizeW'(1);
        found_d = found_n;
        err_d   = err_n;
        if (pend_q) begin
          if (late_fire) begin
            pend_d = 1'b0;
          end else begin
            cnt_d = cnt_q - CntW'(1);
          end
        end
        if (hit && !too_near) begin
          pend_d = 1'b1;
          cnt_d  = CntW'(2);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      found_q <= 1'b0;
      err_q   <= 1'b0;
      pend_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      pos_q   <= pos_d;
      found_q <= found_d;
      err_q   <= err_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[sv/flash_image_autoload_patcher_core.sv]
// ----------------------------------------------------------------------------
// flash_image_autoload_patcher_core
// streams a firmware image through an eight-cell delay line and patches the
// autoload bytes behind the first signature
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------
//  in      | sink      | in_valid_i / in_stall_o  | data_byte_i
//  out     | source    | out_valid_o / out_stall_i| out_byte_o, is_last_o,
//          |           |                          | was_patched_o, too_small_o
//  cfg     | sink      | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
//  one item per cycle with no drain and no output stall; each item shifts the
//  eight-cell chain by one and the oldest held byte leaves as a result item
//  the last item of an image starts a drain: the chain shifts once a cycle
//  while the output is free, input is stalled, then the next image may start
//  reset clears valid and drain bits, image position and search state
//  a stalled output holds its item; the chain waits for a free output slot
// ----------------------------------------------------------------------------
`default_nettype none

module flash_image_autoload_patcher_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration writes
  input  wire logic                              cfg_we_i,
  input  wire logic [fiap_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [fiap_pkg::CfgDataW-1:0]     cfg_data_i,
  // input items
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [fiap_pkg::ByteW-1:0]        data_byte_i,
  // result items
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [fiap_pkg::ByteW-1:0]             out_byte_o,
  output logic                                   is_last_o,
  output logic                                   was_patched_o,
  output logic                                   too_small_o
);

  localparam int unsigned NumCells = fiap_pkg::NumCells;

  // configuration registers
  logic [fiap_pkg::ModeW-1:0] mode_q, mode_d;
  logic [fiap_pkg::SizeW-1:0] size_q, size_d;

  always_comb begin
    mode_d = mode_q;
    size_d = size_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        fiap_pkg::CfgAutoloadMode: mode_d = cfg_data_i[fiap_pkg::ModeW-1:0];
        fiap_pkg::CfgImageSize:    size_d = cfg_data_i[fiap_pkg::SizeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= fiap_pkg::ModeNone;
      size_q <= fiap_pkg::MaxSize;
    end else begin
      mode_q <= mode_d;
      size_q <= size_d;
    end
  end

  // handshake and chain advance
  logic            drain_q, drain_d;
  logic            out_valid_q, out_valid_d;
  fiap_pkg::cell_t out_q, out_d;
  logic            out_free, in_fire, adv;

  // output slot is free when empty or being taken this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = drain_q || !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign adv        = in_fire || (drain_q && out_free);

  // position, search and late patch
  fiap_pkg::trk_t  trk;
  fiap_pkg::cell_t chain [NumCells];
  fiap_pkg::cell_t head;

  fiap_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (in_fire),
    .data_byte_i (data_byte_i),
    .mode_i      (mode_q),
    .size_i      (size_q),
    .win_b0_i    (chain[4].data),   // byte at position - 5
    .win_b1_i    (chain[3].data),   // byte at position - 4
    .trk_o       (trk)
  );

  // new item enters cell 0; during a drain empty entries shift in
  always_comb begin
    head.valid     = in_fire;
    head.data      = trk.data;
    head.last      = trk.last;
    head.patched   = trk.last && trk.patched;
    head.too_small = trk.last && trk.too_small;
  end

  // cell k holds the byte at position - 1 - k; the signature + 2 byte sits in
  // cell 2 when the signature closes, so its patch lands on the way to cell 3
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    fiap_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .prev_i     ((k == 0) ? head : chain[(k == 0) ? 0 : k-1]),
      .ovr_en_i   ((k == 3) && trk.patch_en),
      .ovr_byte_i (trk.patch_byte),
      .cur_o      (chain[k])
    );
  end

  // output register and drain control
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    drain_d     = drain_q;
    if (in_fire && trk.last) begin
      drain_d = 1'b1;
    end
    if (adv && chain[NumCells-1].valid) begin
      out_valid_d = 1'b1;
      out_d       = chain[NumCells-1];
      // the final item of the image leaves the chain
      if (chain[NumCells-1].last) begin
        drain_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      drain_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      drain_q     <= drain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_q.data;
  assign is_last_o     = out_q.last;
  assign was_patched_o = out_q.patched;
  assign too_small_o   = out_q.too_small;

  // checks
  a_drain_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> in_stall_o)
    else $error("input taken during drain");

  a_last_starts_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && trk.last) |=> drain_q)
    else $error("last item did not start a drain");

  a_flags_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (was_patched_o || too_small_o)) |-> is_last_o)
    else $error("status flag on an item that is not last");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(was_patched_o && too_small_o))
    else $error("patched and too small together");

endmodule

`default_nettype wire
